// File: hw/rtl/gdps_pkg.sv
// Package for the grid shortest-path search core: sizes, codes, payload types
// and the controller/datapath command and status structs. No dependencies.
package gdps_pkg;

  localparam int unsigned MaxNodes  = 4096;
  localparam int unsigned IdxW      = $clog2(MaxNodes);
  localparam int unsigned GrayW     = 8;
  localparam int unsigned DistW     = 32;
  localparam int unsigned SideW     = 7;
  localparam int unsigned SideMax   = 64;
  localparam int unsigned CfgIdxW   = 2;
  localparam logic [DistW-1:0] DistInf = '1;
  localparam logic [8:0] EdgeScale = 9'd255;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNREACH  = 2'd1,
    ST_RANGE    = 2'd2,
    ST_RESERVED = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_SPARE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdxW-1:0]  node_index;
    logic [GrayW-1:0] pixel_value;
    logic [IdxW-1:0]  goal_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [DistW-1:0] distance;
    logic [IdxW-1:0]  predecessor;
  } out_item_t;

  // Datapath operations, one issued per cycle by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_INIT,      // set node at clear counter to its reset value
    OP_LOAD,      // write gray store at the item address
    OP_CLR,       // initialise node at clear counter
    OP_SEED,      // start distance to zero
    OP_SCAN_RD,   // issue read of node at scan counter
    OP_SCAN_CMP,  // compare read node against running minimum
    OP_SEL,       // mark best done, read best gray and distance
    OP_NB_RD,     // read neighbour number nb
    OP_NB_CALC,   // register edge sum
    OP_NB_WR,     // write back relaxed neighbour
    OP_FIN_RD,    // read the node at the result address
    OP_FIN        // capture result
  } op_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_SEED, S_SCAN_RD, S_SCAN_CMP, S_SCAN_END, S_SEL,
    S_NB_RD, S_NB_CALC, S_NB_WR, S_FIN_RD, S_FIN, S_OUT
  } state_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] addr;   // clear, scan or result address
    logic [1:0]      nb;     // neighbour number
    logic            scan_first;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic best_is_goal;
    logic nb_valid;          // neighbour exists and is not done
  } dp_stat_t;

  function automatic logic [IdxW:0] clamp_side(input logic [SideW-1:0] v);
    if (v == '0) return (IdxW+1)'(1);
    if (v > SideW'(SideMax)) return (IdxW+1)'(SideMax);
    return (IdxW+1)'(v);
  endfunction

endpackage

// File: hw/rtl/gdps_datapath.sv
// Datapath of the grid search core: node memories, minimum scan registers and
// the edge relaxation arithmetic. Depends on gdps_pkg.
module gdps_datapath
  import gdps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  in_item_t         item_i,
  input  logic [IdxW:0]    width_i,
  input  logic [IdxW:0]    count_i,
  input  logic [DistW-1:0] limit_i,
  output dp_stat_t         stat_o,
  output logic [DistW-1:0] res_dist_o,
  output logic [IdxW-1:0]  res_pred_o
);

  logic [GrayW-1:0] gray_mem [MaxNodes];
  logic [DistW-1:0] dist_mem [MaxNodes];
  logic [IdxW-1:0]  pred_mem [MaxNodes];
  logic             done_mem [MaxNodes];

  logic [GrayW-1:0] rd_gray_q;
  logic [DistW-1:0] rd_dist_q;
  logic [IdxW-1:0]  rd_pred_q;
  logic             rd_done_q;
  logic [IdxW-1:0]  rd_addr_q;

  logic [DistW-1:0] min_q;
  logic [IdxW-1:0]  best_q;
  logic             found_q;
  logic [GrayW-1:0] best_gray_q;
  logic [DistW-1:0] best_dist_q;
  logic [IdxW-1:0]  best_row_q, best_col_q;
  logic [IdxW-1:0]  nb_addr_q;
  logic             nb_ok_q;
  logic [DistW-1:0] sum_q;
  logic [DistW-1:0] res_dist_q;
  logic [IdxW-1:0]  res_pred_q;

  // Neighbour address and existence from the row/column of the selected node.
  logic [IdxW:0]   nb_wide;
  logic            nb_exists;
  logic [IdxW-1:0] rd_addr;
  logic            rd_en;

  always_comb begin
    nb_wide   = '0;
    nb_exists = 1'b0;
    case (cmd_i.nb)
      2'd0: begin
        nb_wide   = {1'b0, best_q} + width_i;
        nb_exists = nb_wide < count_i;
      end
      2'd1: begin
        nb_wide   = {1'b0, best_q} - width_i;
        nb_exists = best_row_q != '0;
      end
      2'd2: begin
        nb_wide   = {1'b0, best_q} + (IdxW+1)'(1);
        nb_exists = ((IdxW+1)'(best_col_q) + (IdxW+1)'(1) < width_i) && (nb_wide < count_i);
      end
      default: begin
        nb_wide   = {1'b0, best_q} - (IdxW+1)'(1);
        nb_exists = best_col_q != '0;
      end
    endcase
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = cmd_i.addr;
    case (cmd_i.op)
      OP_SEL:    rd_addr = best_q;
      OP_NB_RD:  rd_addr = nb_wide[IdxW-1:0];
      OP_SCAN_RD, OP_FIN_RD: rd_addr = cmd_i.addr;
      default:   rd_en = 1'b0;
    endcase
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      gray_mem[item_i.node_index] <= item_i.pixel_value;
    end
    if (cmd_i.op == OP_INIT) begin
      dist_mem[cmd_i.addr] <= DistInf;
      pred_mem[cmd_i.addr] <= '0;
      done_mem[cmd_i.addr] <= 1'b0;
    end
    if (cmd_i.op == OP_CLR) begin
      dist_mem[cmd_i.addr] <= DistInf;
      pred_mem[cmd_i.addr] <= item_i.node_index;
      done_mem[cmd_i.addr] <= 1'b0;
    end
    if (cmd_i.op == OP_SEED) begin
      dist_mem[item_i.node_index] <= '0;
    end
    if (cmd_i.op == OP_SEL) begin
      done_mem[best_q] <= 1'b1;
    end
    if (cmd_i.op == OP_NB_WR && nb_ok_q && sum_q < rd_dist_q) begin
      dist_mem[nb_addr_q] <= sum_q;
      pred_mem[nb_addr_q] <= best_q;
    end
    if (rd_en) begin
      rd_gray_q <= gray_mem[rd_addr];
      rd_dist_q <= dist_mem[rd_addr];
      rd_pred_q <= pred_mem[rd_addr];
      rd_done_q <= done_mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Edge cost from the registered neighbour read.
  logic [GrayW-1:0]   diff;
  logic [GrayW+8:0]   cost;
  logic [DistW:0]     sum_wide;

  always_comb begin
    diff     = (rd_gray_q > best_gray_q) ? rd_gray_q - best_gray_q : best_gray_q - rd_gray_q;
    cost     = EdgeScale * diff;
    if (rd_gray_q < best_gray_q) cost = cost >> 1;
    sum_wide = {1'b0, best_dist_q} + (DistW+1)'(cost);
  end

  // Row and column of the best node: at most 64 columns, so a short loop of
  // subtractions would be long; instead they are tracked during the scan.
  logic [IdxW-1:0] scan_row_q, scan_col_q, scan_row_d, scan_col_d;

  always_comb begin
    scan_row_d = scan_row_q;
    scan_col_d = scan_col_q;
    if ((IdxW+1)'(scan_col_q) + (IdxW+1)'(1) >= width_i) begin
      scan_col_d = '0;
      scan_row_d = scan_row_q + IdxW'(1);
    end else begin
      scan_col_d = scan_col_q + IdxW'(1);
    end
  end

  // The node under compare is selectable and beats the running minimum.
  logic scan_hit;
  assign scan_hit = !rd_done_q && rd_gray_q != '0
                    && rd_dist_q < ((cmd_i.scan_first) ? limit_i : min_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.op == OP_SCAN_CMP) begin
      found_q <= scan_hit || (found_q && !cmd_i.scan_first);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_SCAN_CMP: begin
        if (cmd_i.scan_first) begin
          scan_row_q <= '0;
          scan_col_q <= '0;
        end else begin
          scan_row_q <= scan_row_d;
          scan_col_q <= scan_col_d;
        end
        if (scan_hit) begin
          min_q      <= rd_dist_q;
          best_q     <= rd_addr_q;
          best_row_q <= cmd_i.scan_first ? '0 : scan_row_d;
          best_col_q <= cmd_i.scan_first ? '0 : scan_col_d;
        end else if (cmd_i.scan_first) begin
          min_q <= limit_i;
        end
      end
      OP_NB_RD: begin
        nb_addr_q <= nb_wide[IdxW-1:0];
        nb_ok_q   <= nb_exists;
      end
      OP_NB_CALC: begin
        nb_ok_q <= nb_ok_q && !rd_done_q;
        sum_q   <= sum_wide[DistW] ? DistInf : sum_wide[DistW-1:0];
      end
      OP_FIN: begin
        res_dist_q <= rd_dist_q;
        res_pred_q <= rd_pred_q;
      end
      default: ;
    endcase
    if (cmd_i.op == OP_NB_RD && cmd_i.nb == 2'd0) begin
      best_gray_q <= rd_gray_q;
      best_dist_q <= rd_dist_q;
    end
  end

  assign stat_o.found        = found_q;
  assign stat_o.best_is_goal = best_q == item_i.goal_index;
  assign stat_o.nb_valid     = nb_ok_q;
  assign res_dist_o          = res_dist_q;
  assign res_pred_o          = res_pred_q;

endmodule

// File: hw/rtl/gdps_ctrl.sv
// Controller of the grid search core: sequences load, clear, scan, relax and
// read operations and runs the item handshake. Depends on gdps_pkg.
module gdps_ctrl
  import gdps_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_item_t      item_i,
  input  logic [IdxW:0] count_i,
  input  dp_stat_t      stat_i,
  output dp_cmd_t       cmd_o,
  output logic          out_load_o,
  output logic [1:0]    out_status_o,
  output logic          out_plain_o,
  input  logic          out_free_i
);

  state_e          state_q, state_d;
  logic [IdxW:0]   cnt_q, cnt_d;
  logic [1:0]      nb_q, nb_d;
  logic            first_q, first_d;
  logic [1:0]      st_q, st_d;
  logic            plain_q, plain_d;

  logic start_ok, idx_ok;
  assign idx_ok   = {1'b0, item_i.node_index} < count_i;
  assign start_ok = idx_ok && ({1'b0, item_i.goal_index} < count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      nb_q    <= '0;
      first_q <= 1'b0;
      st_q    <= ST_OK;
      plain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nb_q    <= nb_d;
      first_q <= first_d;
      st_q    <= st_d;
      plain_q <= plain_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    nb_d       = nb_q;
    first_d    = first_q;
    st_d       = st_q;
    plain_d    = plain_q;
    cmd_o      = '{op: OP_IDLE, addr: cnt_q[IdxW-1:0], nb: nb_q, scan_first: first_q};
    in_stall_o = 1'b1;
    out_load_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        // Every node starts unreached, so a read before any run is defined.
        cmd_o.op = OP_INIT;
        cnt_d    = cnt_q + (IdxW+1)'(1);
        if (cnt_q == (IdxW+1)'(MaxNodes - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (kind_e'(item_i.kind))
            KIND_LOAD: begin
              if (idx_ok) cmd_o.op = OP_LOAD;
              st_d    = idx_ok ? ST_OK : ST_RANGE;
              plain_d = 1'b1;
              state_d = S_OUT;
            end
            KIND_RUN: begin
              if (start_ok) begin
                cnt_d   = '0;
                state_d = S_CLR;
              end else begin
                st_d    = ST_RANGE;
                plain_d = 1'b1;
                state_d = S_OUT;
              end
            end
            KIND_READ: begin
              if (idx_ok) begin
                st_d    = ST_OK;
                state_d = S_FIN_RD;
              end else begin
                st_d    = ST_RANGE;
                plain_d = 1'b1;
                state_d = S_OUT;
              end
            end
            default: begin
              st_d    = ST_RANGE;
              plain_d = 1'b1;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_CLR: begin
        cmd_o.op = OP_CLR;
        cnt_d    = cnt_q + (IdxW+1)'(1);
        if (cnt_q + (IdxW+1)'(1) >= count_i) state_d = S_SEED;
      end
      S_SEED: begin
        cmd_o.op = OP_SEED;
        cnt_d    = '0;
        first_d  = 1'b1;
        state_d  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.op = OP_SCAN_RD;
        state_d  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        // Per node: the read, then the compare of the read data.
        cmd_o.op = OP_SCAN_CMP;
        first_d  = 1'b0;
        cnt_d    = cnt_q + (IdxW+1)'(1);
        state_d  = (cnt_q + (IdxW+1)'(1) >= count_i) ? S_SCAN_END : S_SCAN_RD;
      end
      S_SCAN_END: begin
        if (!stat_i.found) begin
          st_d    = ST_UNREACH;
          state_d = S_FIN_RD;
        end else begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        cmd_o.op = OP_SEL;
        nb_d     = '0;
        if (stat_i.best_is_goal) begin
          st_d    = ST_OK;
          state_d = S_FIN_RD;
        end else begin
          state_d = S_NB_RD;
        end
      end
      S_NB_RD: begin
        cmd_o.op = OP_NB_RD;
        state_d  = S_NB_CALC;
      end
      S_NB_CALC: begin
        cmd_o.op = OP_NB_CALC;
        state_d  = S_NB_WR;
      end
      S_NB_WR: begin
        cmd_o.op = OP_NB_WR;
        nb_d     = nb_q + 2'd1;
        if (nb_q == 2'd3) begin
          cnt_d   = '0;
          first_d = 1'b1;
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_NB_RD;
        end
      end
      S_FIN_RD: begin
        cmd_o.op   = OP_FIN_RD;
        cmd_o.addr = (kind_e'(item_i.kind) == KIND_RUN) ? item_i.goal_index
                                                       : item_i.node_index;
        plain_d    = 1'b0;
        state_d    = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_status_o = st_q;
  assign out_plain_o  = plain_q;

endmodule

// File: hw/rtl/grid_dijkstra_path_search_core.sv
// Top level of the grid shortest-path search core: configuration registers,
// input item capture and the output register. Depends on gdps_pkg,
// gdps_ctrl and gdps_datapath.

// After reset the core marks every node unreached before it takes its first item.
// A run clears the N = width*height nodes, then for each round scans all N nodes,
// a read and then a compare per node through the single read port of the node
// memories, and relaxes the four neighbours of the selected node. The gray store
// is undefined until loaded.
module grid_dijkstra_path_search_core
  import gdps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [DistW-1:0]     cfg_data_i
);

  logic [SideW-1:0] width_q, height_q;
  logic [DistW-1:0] limit_q;
  in_item_t         item_q;
  logic             out_valid_q;
  out_item_t        out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideW'(SideMax);
      height_q <= SideW'(SideMax);
      limit_q  <= DistW'(100000);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_WIDTH:  width_q  <= cfg_data_i[SideW-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[SideW-1:0];
        REG_LIMIT:  limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [IdxW:0]   w_side, h_side, count;
  logic [2*IdxW+1:0] prod;
  assign w_side = clamp_side(width_q);
  assign h_side = clamp_side(height_q);
  assign prod   = w_side * h_side;
  assign count  = prod[IdxW:0];

  logic     in_stall, out_load, plain;
  logic [1:0] st;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [DistW-1:0] res_dist;
  logic [IdxW-1:0]  res_pred;
  in_item_t cur_item;

  // The controller sees the live item in its idle cycle, the held copy after.
  assign cur_item = in_stall ? item_q : in_item_i;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall) item_q <= in_item_i;
  end

  gdps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall),
    .item_i      (cur_item),
    .count_i     (count),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .out_load_o  (out_load),
    .out_status_o(st),
    .out_plain_o (plain),
    .out_free_i  (!out_valid_q || !out_stall_i)
  );

  gdps_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .item_i    (cur_item),
    .width_i   (w_side),
    .count_i   (count),
    .limit_i   (limit_q),
    .stat_o    (stat),
    .res_dist_o(res_dist),
    .res_pred_o(res_pred)
  );

  assign in_stall_o = in_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.status <= st;
      if (plain) begin
        out_q.distance    <= (kind_e'(item_q.kind) == KIND_LOAD) ? '0 : DistInf;
        out_q.predecessor <= (kind_e'(item_q.kind) == KIND_RUN) ? item_q.node_index : '0;
      end else begin
        out_q.distance    <= res_dist;
        out_q.predecessor <= res_pred;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result not presented after load");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !out_load)
    else $error("result overwritten while stalled");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status != ST_RESERVED))
    else $error("reserved status code");
`endif

endmodule

// File: test/grid_dijkstra_path_search_core_tb.sv
// Self-checking testbench for grid_dijkstra_path_search_core: a queue-fed driver, a
// monitor against a shortest-path predictor, and register writes between phases.
// Depends on gdps_pkg and the core RTL.
module grid_dijkstra_path_search_core_tb;
  import gdps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 400000;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid;
  logic            in_stall;
  in_item_t        in_item;
  logic            out_valid;
  logic            out_stall;
  out_item_t       out_item;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DistW-1:0]   cfg_data;

  grid_dijkstra_path_search_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Predictor state: configuration and the node stores.
  logic [6:0]       grid_w, grid_h;
  logic [31:0]      dist_limit;
  logic [7:0]       gray_mem [MaxNodes];
  logic [31:0]      dist_mem [MaxNodes];
  logic [IdxW-1:0]  pred_mem [MaxNodes];
  bit               done_mem [MaxNodes];

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        mismatches;
  int        idle_cycles;
  bit        no_idle;

  function automatic int side_of(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic int nodes_now();
    return side_of(grid_w) * side_of(grid_h);
  endfunction

  function automatic void relax_edge(int from, int to);
    logic [31:0] cost;
    logic [32:0] sum;
    int gf, gt, diff;
    if (done_mem[to]) return;
    gf = gray_mem[from];
    gt = gray_mem[to];
    diff = (gt > gf) ? gt - gf : gf - gt;
    cost = 32'(255 * diff);
    if (gt < gf) cost = cost >> 1;
    sum = {1'b0, dist_mem[from]} + {1'b0, cost};
    if (sum[32]) sum[31:0] = DistInf;
    if (sum[31:0] < dist_mem[to]) begin
      dist_mem[to] = sum[31:0];
      pred_mem[to] = IdxW'(from);
    end
  endfunction

  function automatic bit search_path(int s, int g, int n);
    int w, i, best, round;
    logic [31:0] lowest;
    bit found;
    w = side_of(grid_w);
    for (i = 0; i < n; i++) begin
      dist_mem[i] = DistInf;
      pred_mem[i] = IdxW'(s);
      done_mem[i] = 0;
    end
    dist_mem[s] = 0;
    for (round = 0; round < n; round++) begin
      lowest = dist_limit;
      found = 0;
      best = 0;
      for (i = 0; i < n; i++) begin
        if (!done_mem[i] && gray_mem[i] != 0 && dist_mem[i] < lowest) begin
          lowest = dist_mem[i];
          best = i;
          found = 1;
        end
      end
      if (!found) return 0;
      done_mem[best] = 1;
      if (best == g) return 1;
      if (best + w < n) relax_edge(best, best + w);
      if (best / w > 0) relax_edge(best, best - w);
      if ((best % w) + 1 < w && best + 1 < n) relax_edge(best, best + 1);
      if (best % w > 0) relax_edge(best, best - 1);
    end
    return done_mem[g];
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int n;
    n = nodes_now();
    r.status = ST_RANGE;
    r.distance = DistInf;
    r.predecessor = '0;
    case (kind_e'(it.kind))
      KIND_LOAD: begin
        r.distance = '0;
        if (it.node_index < n) begin
          gray_mem[it.node_index] = it.pixel_value;
          r.status = ST_OK;
        end
      end
      KIND_RUN: begin
        r.predecessor = it.node_index;
        if (it.node_index < n && it.goal_index < n) begin
          r.status = search_path(it.node_index, it.goal_index, n) ? ST_OK : ST_UNREACH;
          r.distance = dist_mem[it.goal_index];
          r.predecessor = pred_mem[it.goal_index];
        end
      end
      KIND_READ: begin
        if (it.node_index < n) begin
          r.status = ST_OK;
          r.distance = dist_mem[it.node_index];
          r.predecessor = pred_mem[it.node_index];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: prediction is made as each item is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 0;
      in_item <= '0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_result(in_item));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && (no_idle || $urandom_range(0, 99) >= 27)) begin
          in_valid <= 1;
          in_item <= pending_items.pop_front();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 0;
    end else begin
      out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 27);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_item);
        end else begin
          if (out_item !== expected_results[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d dist %h pred %0d, got %0d %h %0d",
                       expected_results[0].status, expected_results[0].distance,
                       expected_results[0].predecessor, out_item.status,
                       out_item.distance, out_item.predecessor);
          end
          void'(expected_results.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("[grid_dijkstra_path_search_core] ERROR");
      $finish;
    end
  end

  task automatic push_item(kind_e k, int idx, int pix, int goal);
    in_item_t it;
    it.kind = k;
    it.node_index = IdxW'(idx);
    it.pixel_value = GrayW'(pix);
    it.goal_index = IdxW'(goal);
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_WIDTH:  grid_w = data[6:0];
      REG_HEIGHT: grid_h = data[6:0];
      REG_LIMIT:  dist_limit = data;
      default: ;
    endcase
  endtask

  task automatic setup_grid(logic [31:0] w, logic [31:0] h, logic [31:0] lim);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_LIMIT, lim);
  endtask

  // Every pixel of the grid is loaded before any search can scan it.
  task automatic load_image();
    int i;
    for (i = 0; i < nodes_now(); i++)
      push_item(KIND_LOAD, i, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255), 0);
  endtask

  task automatic random_items(int count);
    int i, n, r;
    n = nodes_now();
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50)
        push_item(KIND_RUN, $urandom_range(0, n - 1), $urandom_range(0, 255),
                  $urandom_range(0, n - 1));
      else if (r < 78)
        push_item(KIND_READ, $urandom_range(0, n - 1), $urandom_range(0, 255),
                  $urandom_range(0, 4095));
      else if (r < 90)
        push_item(KIND_LOAD, $urandom_range(0, n - 1), $urandom_range(0, 255),
                  $urandom_range(0, 4095));
      else
        push_item(kind_e'($urandom_range(0, 3)), $urandom_range(0, 4095),
                  $urandom_range(0, 255), $urandom_range(0, 4095));
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < MaxNodes; i++) begin
      gray_mem[i] = 0;
      dist_mem[i] = DistInf;
      pred_mem[i] = '0;
      done_mem[i] = 0;
    end
    grid_w = 64;
    grid_h = 64;
    dist_limit = 100000;
    mismatches = 0;
    idle_cycles = 0;
    no_idle = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // Reset state: a read before any search and an unknown kind.
    push_item(KIND_READ, 4095, 0, 0);
    push_item(KIND_NONE, 7, 255, 4095);

    setup_grid(4, 4, 100000);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    // Directed 4 x 4 image with walls at 5 and 10.
    for (i = 0; i < 16; i++)
      push_item(KIND_LOAD, i, (i == 5 || i == 10) ? 0 : ((i == 0) ? 255 : (i * 16 + 1)), 0);
    push_item(KIND_LOAD, 16, 255, 0);
    push_item(KIND_LOAD, 4095, 255, 4095);
    push_item(KIND_RUN, 0, 0, 15);
    push_item(KIND_READ, 15, 0, 0);
    push_item(KIND_READ, 5, 0, 0);
    push_item(KIND_RUN, 3, 0, 3);
    push_item(KIND_RUN, 0, 0, 5);
    push_item(KIND_RUN, 10, 0, 0);
    push_item(KIND_RUN, 16, 0, 0);
    push_item(KIND_RUN, 0, 0, 4095);
    push_item(KIND_READ, 16, 0, 0);
    push_item(KIND_NONE, 0, 0, 0);

    setup_grid(4, 4, 32'hFFFF_FFFF);
    random_items(8);
    // Hold off until every pending result is back, then carry on.
    drain();
    random_items(4);

    // A width above 64 counts as 64; only reads and loads, no scan.
    setup_grid(127, 1, 100000);
    push_item(KIND_READ, 63, 0, 0);
    push_item(KIND_READ, 64, 0, 0);
    push_item(KIND_LOAD, 64, 9, 0);
    push_item(KIND_READ, 40, 0, 0);

    setup_grid(0, 5, 300);
    load_image();
    random_items(8);

    setup_grid(2, 3, 32'hFFFF_FFFF);
    load_image();
    no_idle = 1;
    random_items(8);

    setup_grid(2, 2, 0);
    no_idle = 0;
    load_image();
    random_items(5);

    setup_grid(3, 3, 600);
    load_image();
    random_items(6);

    setup_grid(3, 2, $urandom());
    load_image();
    random_items(5);

    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("[grid_dijkstra_path_search_core] OK");
    else
      $display("[grid_dijkstra_path_search_core] ERROR");
    $finish;
  end

endmodule
